@@ rtl/core/tlpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the page-table engine
// Action and status codes, the command word passed from the front end to the
// back end through the queue, and the back-end state encoding.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int PAGE_BYTES    = 4096;
    localparam int OFFSET_W      = 12;
    localparam int PAGE_NUM_W    = 20;
    localparam int DIR_W         = 10;
    localparam int COUNT_W       = 21;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [1:0] ACT_INIT      = 2'd0;
    localparam logic [1:0] ACT_MAP_COUNT = 2'd1;
    localparam logic [1:0] ACT_MAP_END   = 2'd2;
    localparam logic [1:0] ACT_TRANSLATE = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    typedef enum logic [1:0] {
        KIND_REPORT,
        KIND_WALK,
        KIND_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [1:0]              status;
        logic [PAGE_NUM_W-1:0]   vpn;
        logic [PAGE_NUM_W-1:0]   ppn;
        logic [COUNT_W-1:0]      count;
        logic [OFFSET_W-1:0]     flags;
        logic [OFFSET_W-1:0]     offset;
    } cmd_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_WALK,
        BACK_READ
    } back_state_t;

endpackage

@@ rtl/core/tlpt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_front: command classifier
// Checks alignment and bounds of an incoming word and turns it into a walk,
// a table read or an immediate status report for the back end.
// ----------------------------------------------------------------------------
module tlpt_front #(
    parameter int DIR_SLOTS_KEPT = 4
) (
    input  logic [1:0]  action,
    input  logic [31:0] virt_addr,
    input  logic [31:0] phys_addr,
    input  logic [31:0] phys_limit,
    input  logic [20:0] page_count,
    input  logic [11:0] flags,
    output tlpt_pkg::cmd_t cmd
);
    import tlpt_pkg::*;

    localparam int KEPT_ENTRIES = DIR_SLOTS_KEPT * TABLE_ENTRIES;

    logic                 misaligned;
    logic [COUNT_W-1:0]   span;
    logic                 dir_out;

    assign misaligned = (virt_addr[OFFSET_W-1:0] != '0) || (phys_addr[OFFSET_W-1:0] != '0);
    assign span = {1'b0, phys_limit[31:OFFSET_W]} - {1'b0, phys_addr[31:OFFSET_W]};
    assign dir_out = {1'b0, virt_addr[31:32-DIR_W]} >= (DIR_W+1)'(DIR_SLOTS_KEPT);

    always_comb
    begin
        cmd.kind   = KIND_REPORT;
        cmd.status = STATUS_OK;
        cmd.vpn    = virt_addr[31:OFFSET_W];
        cmd.ppn    = phys_addr[31:OFFSET_W];
        cmd.count  = page_count;
        cmd.flags  = flags;
        cmd.offset = virt_addr[OFFSET_W-1:0];
        case (action)
            ACT_INIT:
            begin
                cmd.kind  = KIND_WALK;
                cmd.vpn   = '0;
                cmd.ppn   = '0;
                cmd.count = COUNT_W'(KEPT_ENTRIES);
            end
            ACT_MAP_COUNT:
            begin
                if (misaligned)
                begin
                    cmd.status = STATUS_INVALID;
                end
                else
                begin
                    cmd.kind = KIND_WALK;
                end
            end
            ACT_MAP_END:
            begin
                if (misaligned || (phys_limit[OFFSET_W-1:0] != '0) || span[COUNT_W-1])
                begin
                    cmd.status = STATUS_INVALID;
                end
                else
                begin
                    cmd.kind  = KIND_WALK;
                    cmd.count = span;
                end
            end
            default:
            begin
                if (dir_out)
                begin
                    cmd.status = STATUS_RANGE;
                end
                else
                begin
                    cmd.kind = KIND_READ;
                end
            end
        endcase
    end

endmodule

@@ rtl/core/tlpt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_queue: command queue
// Two-entry first-in first-out buffer that decouples the classifier from the
// back end.
// ----------------------------------------------------------------------------
module tlpt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tlpt_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tlpt_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import tlpt_pkg::*;

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] fill_reg;
    logic [QUEUE_CNT_W-1:0] fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tlpt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_back: table walker and lookup
// Holds the page-table memory, writes runs of entries one per cycle, reads an
// entry for a translation and drives the result strobe.
// ----------------------------------------------------------------------------
module tlpt_back #(
    parameter int DIR_SLOTS_KEPT = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_ready,
    input  tlpt_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           done,
    output logic [1:0]     status,
    output logic [31:0]    entry,
    output logic [31:0]    phys_out
);
    import tlpt_pkg::*;

    localparam int KEPT_ENTRIES = DIR_SLOTS_KEPT * TABLE_ENTRIES;
    localparam int IDX_W        = $clog2(KEPT_ENTRIES);

    logic [31:0]           page_entries_mem [KEPT_ENTRIES];
    logic [31:0]           rd_data_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [PAGE_NUM_W-1:0] vpn_reg;
    logic [PAGE_NUM_W-1:0] vpn_next;
    logic [PAGE_NUM_W-1:0] ppn_reg;
    logic [PAGE_NUM_W-1:0] ppn_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [OFFSET_W-1:0]   flags_reg;
    logic [OFFSET_W-1:0]   flags_next;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [OFFSET_W-1:0]   offset_next;
    logic                  done_reg;
    logic                  done_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [31:0]           entry_reg;
    logic [31:0]           entry_next;
    logic [31:0]           phys_out_reg;
    logic [31:0]           phys_out_next;

    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      rd_idx;
    logic                  walk_out;

    assign walk_out = {1'b0, vpn_reg[PAGE_NUM_W-1:PAGE_NUM_W-DIR_W]} >= (DIR_W+1)'(DIR_SLOTS_KEPT);
    assign rd_idx   = cmd.vpn[IDX_W-1:0];

    assign done     = done_reg;
    assign status   = status_reg;
    assign entry    = entry_reg;
    assign phys_out = phys_out_reg;

    always_comb
    begin
        state_next    = state_reg;
        vpn_next      = vpn_reg;
        ppn_next      = ppn_reg;
        count_next    = count_reg;
        flags_next    = flags_reg;
        offset_next   = offset_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        entry_next    = entry_reg;
        phys_out_next = phys_out_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                if (cmd_ready)
                begin
                    cmd_pop     = 1'b1;
                    vpn_next    = cmd.vpn;
                    ppn_next    = cmd.ppn;
                    count_next  = cmd.count;
                    flags_next  = cmd.flags;
                    offset_next = cmd.offset;
                    case (cmd.kind)
                        KIND_WALK:
                        begin
                            if (cmd.count == '0)
                            begin
                                done_next     = 1'b1;
                                status_next   = STATUS_OK;
                                entry_next    = '0;
                                phys_out_next = '0;
                            end
                            else
                            begin
                                state_next = BACK_WALK;
                            end
                        end
                        KIND_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = BACK_READ;
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            status_next   = cmd.status;
                            entry_next    = '0;
                            phys_out_next = '0;
                        end
                    endcase
                end
            end
            BACK_WALK:
            begin
                if (walk_out)
                begin
                    done_next     = 1'b1;
                    status_next   = STATUS_RANGE;
                    entry_next    = '0;
                    phys_out_next = '0;
                    state_next    = BACK_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    vpn_next   = vpn_reg + 1'b1;
                    ppn_next   = ppn_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == COUNT_W'(1))
                    begin
                        done_next     = 1'b1;
                        status_next   = STATUS_OK;
                        entry_next    = '0;
                        phys_out_next = '0;
                        state_next    = BACK_IDLE;
                    end
                end
            end
            BACK_READ:
            begin
                done_next     = 1'b1;
                status_next   = STATUS_OK;
                entry_next    = rd_data_reg;
                phys_out_next = {rd_data_reg[31:OFFSET_W], offset_reg};
                state_next    = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        flags_reg    <= flags_next;
        offset_reg   <= offset_next;
        status_reg   <= status_next;
        entry_reg    <= entry_next;
        phys_out_reg <= phys_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_entries_mem[vpn_reg[IDX_W-1:0]] <= {ppn_reg, flags_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= page_entries_mem[rd_idx];
        end
    end

endmodule

@@ rtl/core/two_level_page_table_map_translate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_map_translate_core: page-table engine top level
// Identity init, page-run mapping and address translation over the page
// tables of the lowest directory slots, kept flat in one memory.
// ----------------------------------------------------------------------------
// A command word is taken on a rising edge with start high and busy low; its
// fields are action, virt_addr, phys_addr, phys_limit, page_count and flags.
// Every command gives exactly one result word on status, entry and phys_out,
// shown for a single cycle with done high, in command order.
// A classifier checks each word as it arrives and places it in a two-entry
// queue; busy is high only while that queue is full, so up to two further
// words are taken while the back end works.
// Path from acceptance to done, with the back end free: a rejected word, a
// zero-page map or a translation outside the kept slots is reported as soon as
// the back end takes it, a translation goes through one registered memory
// read, and a map or init writes its entries one per cycle through the
// single memory write port; init writes DIR_SLOTS_KEPT * 1024 entries. A run
// is stopped on leaving the kept slots.
// The back end takes a rejected word every cycle, but finishes a translation
// or a map before it takes the next word.
// Reset empties the queue and returns the back end to idle; the table memory
// is not cleared and an entry must be written before it is translated.
// Results cannot be held off: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module two_level_page_table_map_translate_core #(
    parameter int DIR_SLOTS_KEPT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] virt_addr,
    input  logic [31:0] phys_addr,
    input  logic [31:0] phys_limit,
    input  logic [20:0] page_count,
    input  logic [11:0] flags,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] entry,
    output logic [31:0] phys_out
);
    import tlpt_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    assign busy = queue_full;

    tlpt_front #(
        .DIR_SLOTS_KEPT(DIR_SLOTS_KEPT)
    ) u_front (
        .action     (action),
        .virt_addr  (virt_addr),
        .phys_addr  (phys_addr),
        .phys_limit (phys_limit),
        .page_count (page_count),
        .flags      (flags),
        .cmd        (front_cmd)
    );

    tlpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start),
        .push_cmd (front_cmd),
        .full     (queue_full),
        .pop      (queue_pop),
        .pop_cmd  (queue_cmd),
        .empty    (queue_empty)
    );

    tlpt_back #(
        .DIR_SLOTS_KEPT(DIR_SLOTS_KEPT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ready (!queue_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .done      (done),
        .status    (status),
        .entry     (entry),
        .phys_out  (phys_out)
    );

endmodule

@@ rtl/core/tlpt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_checker: port-level checks of the page-table engine
// Watches the command and result ports and reports rule breaks.
// ----------------------------------------------------------------------------
module tlpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] entry,
    input logic [31:0] phys_out
);
    import tlpt_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_INVALID || status == STATUS_RANGE))
    else $error("result word carries an unknown status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (entry == '0 && phys_out == '0))
    else $error("failed command returned a nonzero entry or address");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (phys_out[31:12] == entry[31:12]))
    else $error("physical page differs from the entry page");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
    else $error("busy rose without a command being taken");

endmodule

bind two_level_page_table_map_translate_core tlpt_checker u_tlpt_checker (.*);
